// ===== sv/c8ie_pkg.sv =====
// Shared types, opcode constants and helper functions for the CHIP-8 execute unit.
// Used by the ALU, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package c8ie_pkg;

  // Machine dimensions.
  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = 12;
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int NUM_REGS    = 16;

  localparam logic [11:0] PC_RESET  = 12'h200;
  localparam logic [11:0] ADDR_LAST = 12'hFFF;
  localparam logic [15:0] INS_CLS   = 16'h00E0;
  localparam logic [3:0]  REG_FLAG  = 4'hF;

  // Operations carried by an input word.
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_PIXEL = 2'd3;

  // Top opcode nibbles.
  localparam logic [3:0] OPC_SYS   = 4'h0;
  localparam logic [3:0] OPC_JP    = 4'h1;
  localparam logic [3:0] OPC_SE_I  = 4'h3;
  localparam logic [3:0] OPC_SNE_I = 4'h4;
  localparam logic [3:0] OPC_SE_R  = 4'h5;
  localparam logic [3:0] OPC_LD_I  = 4'h6;
  localparam logic [3:0] OPC_ADD_I = 4'h7;
  localparam logic [3:0] OPC_ALU   = 4'h8;
  localparam logic [3:0] OPC_SNE_R = 4'h9;
  localparam logic [3:0] OPC_LDI   = 4'hA;
  localparam logic [3:0] OPC_JPV   = 4'hB;
  localparam logic [3:0] OPC_RND   = 4'hC;
  localparam logic [3:0] OPC_DRW   = 4'hD;
  localparam logic [3:0] OPC_MISC  = 4'hF;

  // Register-register ALU sub-codes (low nibble of 8XYN).
  localparam logic [3:0] AS_MOV  = 4'h0;
  localparam logic [3:0] AS_OR   = 4'h1;
  localparam logic [3:0] AS_AND  = 4'h2;
  localparam logic [3:0] AS_XOR  = 4'h3;
  localparam logic [3:0] AS_ADD  = 4'h4;
  localparam logic [3:0] AS_SUB  = 4'h5;
  localparam logic [3:0] AS_SHR  = 4'h6;
  localparam logic [3:0] AS_SUBN = 4'h7;
  localparam logic [3:0] AS_SHL  = 4'hE;

  // FX sub-codes.
  localparam logic [7:0] FS_ADDI  = 8'h1E;
  localparam logic [7:0] FS_BCD   = 8'h33;
  localparam logic [7:0] FS_STORE = 8'h55;
  localparam logic [7:0] FS_LOAD  = 8'h65;

  // Shared ALU operations.
  typedef enum logic [2:0] {
    ALU_PASS = 3'd0,
    ALU_OR   = 3'd1,
    ALU_AND  = 3'd2,
    ALU_XOR  = 3'd3,
    ALU_ADD  = 3'd4,
    ALU_SUB  = 3'd5,
    ALU_SHR  = 3'd6,
    ALU_SHL  = 3'd7
  } alu_op_t;

  typedef struct packed {
    logic [11:0] res;
    logic        flag;
    logic        zero;
  } alu_res_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] instruction;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [7:0]  random_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  target_value;
    logic [7:0]  read_data;
  } out_t;

  // Decimal digits {hundreds, tens, ones} by reciprocal multiplication.
  function automatic logic [11:0] bcd3(input logic [7:0] v);
    logic [15:0] ph;
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  o;
    ph = 16'(v) * 16'd41;
    h  = ph[13:12];
    r  = 7'(v - 8'(h) * 8'd100);
    pt = 15'(r) * 15'd205;
    t  = pt[14:11];
    o  = 4'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o};
  endfunction

  // Places a sprite byte (MSB leftmost) at column col of a 64-pixel row, wrapping.
  function automatic logic [63:0] sprite_mask(input logic [7:0] bits, input logic [5:0] col);
    logic [63:0] ext;
    ext = '0;
    for (int k = 0; k < 8; k++) begin
      ext[k] = bits[7-k];
    end
    return (ext << col) | (ext >> (7'd64 - {1'b0, col}));
  endfunction

endpackage

// ===== sv/c8ie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the register file, program memory and frame buffer.
`timescale 1ns / 1ps

module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/c8ie_alu.sv =====
// Shared arithmetic, logic, shift and compare unit of the execute sequencer.
// Depends on c8ie_pkg for the operation codes and result struct.
`timescale 1ns / 1ps

module c8ie_alu (
  input  c8ie_pkg::alu_op_t  op,
  input  logic [11:0]        a,
  input  logic [11:0]        b,
  output c8ie_pkg::alu_res_t y
);

  logic [12:0] sum;
  logic [12:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  // Result and flag per operation; flags follow 8-bit operand semantics.
  always_comb begin
    y.res  = b;
    y.flag = 1'b0;
    case (op)
      c8ie_pkg::ALU_PASS: y.res = b;
      c8ie_pkg::ALU_OR:   y.res = a | b;
      c8ie_pkg::ALU_AND:  y.res = a & b;
      c8ie_pkg::ALU_XOR:  y.res = a ^ b;
      c8ie_pkg::ALU_ADD: begin
        y.res  = sum[11:0];
        y.flag = sum[8];
      end
      c8ie_pkg::ALU_SUB: begin
        y.res  = diff[11:0];
        y.flag = ~diff[12];
      end
      c8ie_pkg::ALU_SHR: begin
        y.res  = {1'b0, a[11:1]};
        y.flag = a[0];
      end
      c8ie_pkg::ALU_SHL: begin
        y.res  = {a[10:0], 1'b0};
        y.flag = a[7];
      end
      default: y.res = b;
    endcase
    y.zero = (y.res == 12'd0);
  end

endmodule

// ===== sv/chip8_instruction_executor_core.sv =====
// CHIP-8 execute unit top level: sequencer, machine registers and memories.
// Depends on c8ie_pkg, c8ie_ram and c8ie_alu.
`timescale 1ns / 1ps

// Usage: a request word (req, req_valid, req_stall) carries one operation: execute
// an instruction, write or read a memory byte, or read one pixel. Each request
// yields exactly one response word (rsp, rsp_valid, rsp_stall) holding PC, I, VF,
// the register named by the instruction, and the byte or pixel read.
// After reset the unit sweeps program memory, registers and screen to zero with
// req_stall high; PC resets to 0x200.
// Every request passes through three register reads over the single register-file
// port, and most instructions through three write-back steps (VY, VX, VF).
// Draw DXYN handles one sprite row at a time, FX55/FX65 move one register at a time,
// FX33 writes three digit bytes and 00E0 clears one screen row per cycle.
// One request is in work at a time. The response sits in an output register; the
// next request is taken while it waits, but a further response stalls the
// sequencer until rsp_stall drops. A stalled response holds its value.
module chip8_instruction_executor_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  c8ie_pkg::in_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output c8ie_pkg::out_t  rsp
);

  typedef enum logic [23:0] {
    S_CLR  = 24'h000001,
    S_IDLE = 24'h000002,
    S_RX   = 24'h000004,
    S_RY   = 24'h000008,
    S_R0   = 24'h000010,
    S_EXEC = 24'h000020,
    S_MRD  = 24'h000040,
    S_PRD  = 24'h000080,
    S_CLS  = 24'h000100,
    S_WY   = 24'h000200,
    S_WX   = 24'h000400,
    S_WF   = 24'h000800,
    S_DA   = 24'h001000,
    S_DD   = 24'h002000,
    S_B0   = 24'h004000,
    S_B1   = 24'h008000,
    S_B2   = 24'h010000,
    S_S5R  = 24'h020000,
    S_S5W  = 24'h040000,
    S_S6R  = 24'h080000,
    S_S6W  = 24'h100000,
    S_TX   = 24'h200000,
    S_TF   = 24'h400000,
    S_TD   = 24'h800000
  } state_t;

  state_t state;

  c8ie_pkg::in_t cur;
  logic [11:0] pc;
  logic [11:0] idx;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [7:0]  v0;
  logic [7:0]  res;
  logic        flg;
  logic        wx;
  logic        wy;
  logic        wf;
  logic        hit;
  logic [3:0]  j;
  logic [11:0] cnt;
  logic [7:0]  rdat;
  logic [7:0]  tgt;

  // Instruction fields.
  logic [3:0]  top;
  logic [3:0]  rx;
  logic [3:0]  ry;
  logic [3:0]  nib;
  logic [7:0]  nn;
  logic [11:0] nnn;

  assign top = cur.instruction[15:12];
  assign rx  = cur.instruction[11:8];
  assign ry  = cur.instruction[7:4];
  assign nib = cur.instruction[3:0];
  assign nn  = cur.instruction[7:0];
  assign nnn = cur.instruction[11:0];

  logic [11:0] pc2;
  logic [11:0] pc4;
  logic [11:0] bcd;
  logic [4:0]  drow;
  logic [63:0] dmask;

  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;
  assign bcd = c8ie_pkg::bcd3(vx);

  // Register file port.
  logic       v_we;
  logic [3:0] v_waddr;
  logic [7:0] v_wdata;
  logic [3:0] v_raddr;
  logic [7:0] v_q;

  // Program memory port.
  logic        m_we;
  logic [11:0] m_waddr;
  logic [7:0]  m_wdata;
  logic [11:0] m_raddr;
  logic [7:0]  m_q;

  // Frame buffer port, one 64-pixel row per entry.
  logic        f_we;
  logic [4:0]  f_waddr;
  logic [63:0] f_wdata;
  logic [4:0]  f_raddr;
  logic [63:0] f_q;

  assign drow  = 5'(vy[4:0] + {1'b0, j});
  assign dmask = c8ie_pkg::sprite_mask(m_q, vx[5:0]);

  c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::NUM_REGS)) u_vregs (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_q)
  );

  c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_q)
  );

  c8ie_ram #(.WIDTH(c8ie_pkg::SCR_W), .DEPTH(c8ie_pkg::SCR_H)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_q)
  );

  // Operand selection for the shared ALU, used in the execute step.
  c8ie_pkg::alu_op_t  aop;
  logic [11:0]        aa;
  logic [11:0]        ab;
  c8ie_pkg::alu_res_t ay;

  always_comb begin
    aop = c8ie_pkg::ALU_PASS;
    aa  = '0;
    ab  = '0;
    unique case (top)
      c8ie_pkg::OPC_SE_I, c8ie_pkg::OPC_SNE_I: begin
        aop = c8ie_pkg::ALU_SUB;
        aa  = {4'd0, vx};
        ab  = {4'd0, nn};
      end
      c8ie_pkg::OPC_SE_R, c8ie_pkg::OPC_SNE_R: begin
        aop = c8ie_pkg::ALU_SUB;
        aa  = {4'd0, vx};
        ab  = {4'd0, vy};
      end
      c8ie_pkg::OPC_LD_I: ab = {4'd0, nn};
      c8ie_pkg::OPC_ADD_I: begin
        aop = c8ie_pkg::ALU_ADD;
        aa  = {4'd0, vx};
        ab  = {4'd0, nn};
      end
      c8ie_pkg::OPC_ALU: begin
        aa = {4'd0, vx};
        ab = {4'd0, vy};
        unique case (nib)
          c8ie_pkg::AS_OR:  aop = c8ie_pkg::ALU_OR;
          c8ie_pkg::AS_AND: aop = c8ie_pkg::ALU_AND;
          c8ie_pkg::AS_XOR: aop = c8ie_pkg::ALU_XOR;
          c8ie_pkg::AS_ADD: aop = c8ie_pkg::ALU_ADD;
          c8ie_pkg::AS_SUB: aop = c8ie_pkg::ALU_SUB;
          c8ie_pkg::AS_SHR: begin
            aop = c8ie_pkg::ALU_SHR;
            aa  = {4'd0, vy};
          end
          c8ie_pkg::AS_SUBN: begin
            aop = c8ie_pkg::ALU_SUB;
            aa  = {4'd0, vy};
            ab  = {4'd0, vx};
          end
          c8ie_pkg::AS_SHL: begin
            aop = c8ie_pkg::ALU_SHL;
            aa  = {4'd0, vy};
          end
          default: aop = c8ie_pkg::ALU_PASS;
        endcase
      end
      c8ie_pkg::OPC_JPV: begin
        aop = c8ie_pkg::ALU_ADD;
        aa  = {4'd0, v0};
        ab  = nnn;
      end
      c8ie_pkg::OPC_RND: begin
        aop = c8ie_pkg::ALU_AND;
        aa  = {4'd0, cur.random_byte};
        ab  = {4'd0, nn};
      end
      c8ie_pkg::OPC_MISC: begin
        aop = c8ie_pkg::ALU_ADD;
        aa  = idx;
        ab  = {4'd0, vx};
      end
      default: aop = c8ie_pkg::ALU_PASS;
    endcase
  end

  c8ie_alu u_alu (.op(aop), .a(aa), .b(ab), .y(ay));

  // Memory port control per sequencer state.
  always_comb begin
    v_we    = 1'b0;
    v_waddr = rx;
    v_wdata = res;
    v_raddr = c8ie_pkg::REG_FLAG;
    m_we    = 1'b0;
    m_waddr = idx;
    m_wdata = '0;
    m_raddr = idx;
    f_we    = 1'b0;
    f_waddr = drow;
    f_wdata = '0;
    f_raddr = '0;
    unique case (state)
      S_CLR: begin
        v_we    = 1'b1;
        v_waddr = cnt[3:0];
        v_wdata = '0;
        m_we    = 1'b1;
        m_waddr = cnt;
        f_we    = 1'b1;
        f_waddr = cnt[4:0];
      end
      S_IDLE: v_raddr = req.instruction[11:8];
      S_RX:   v_raddr = ry;
      S_RY:   v_raddr = 4'd0;
      S_EXEC: begin
        m_raddr = cur.address;
        f_raddr = cur.address[10:6];
        if (cur.operation == c8ie_pkg::OP_WRITE) begin
          m_we    = 1'b1;
          m_waddr = cur.address;
          m_wdata = cur.write_data;
        end
      end
      S_CLS: begin
        f_we    = 1'b1;
        f_waddr = cnt[4:0];
      end
      S_WY: begin
        v_we    = wy;
        v_waddr = ry;
      end
      S_WX: v_we = wx;
      S_WF: begin
        v_we    = wf;
        v_waddr = c8ie_pkg::REG_FLAG;
        v_wdata = {7'd0, flg};
      end
      S_DA: begin
        m_raddr = idx + {8'd0, j};
        f_raddr = drow;
      end
      S_DD: begin
        f_we    = 1'b1;
        f_wdata = f_q ^ dmask;
      end
      S_B0: begin
        m_we    = 1'b1;
        m_wdata = {4'd0, bcd[11:8]};
      end
      S_B1: begin
        m_we    = 1'b1;
        m_waddr = idx + 12'd1;
        m_wdata = {4'd0, bcd[7:4]};
      end
      S_B2: begin
        m_we    = 1'b1;
        m_waddr = idx + 12'd2;
        m_wdata = {4'd0, bcd[3:0]};
      end
      S_S5R: v_raddr = j;
      S_S5W: begin
        m_we    = 1'b1;
        m_wdata = v_q;
      end
      S_S6W: begin
        v_we    = 1'b1;
        v_waddr = j;
        v_wdata = m_q;
      end
      S_TX: v_raddr = rx;
      default: v_raddr = c8ie_pkg::REG_FLAG;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // Sequencer and machine registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      pc        <= c8ie_pkg::PC_RESET;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_TD && !(rsp_valid && rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          cnt <= cnt + 12'd1;
          if (cnt == c8ie_pkg::ADDR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            rdat  <= '0;
            state <= S_RX;
          end
        end
        S_RX: begin
          vx    <= v_q;
          state <= S_RY;
        end
        S_RY: begin
          vy    <= v_q;
          state <= S_R0;
        end
        S_R0: begin
          v0    <= v_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res <= ay.res[7:0];
          flg <= ay.flag;
          wx  <= 1'b0;
          wy  <= 1'b0;
          wf  <= 1'b0;
          hit <= 1'b0;
          j   <= '0;
          cnt <= '0;
          unique case (cur.operation)
            c8ie_pkg::OP_WRITE: state <= S_TX;
            c8ie_pkg::OP_READ:  state <= S_MRD;
            c8ie_pkg::OP_PIXEL: state <= S_PRD;
            c8ie_pkg::OP_EXEC: begin
              pc    <= pc2;
              state <= S_WY;
              unique case (top)
                c8ie_pkg::OPC_SYS: begin
                  if (cur.instruction == c8ie_pkg::INS_CLS) begin
                    state <= S_CLS;
                  end
                end
                c8ie_pkg::OPC_JP: pc <= nnn;
                c8ie_pkg::OPC_SE_I: if (ay.zero) pc <= pc4;
                c8ie_pkg::OPC_SNE_I: if (!ay.zero) pc <= pc4;
                c8ie_pkg::OPC_SE_R: if (nib == 4'd0 && ay.zero) pc <= pc4;
                c8ie_pkg::OPC_SNE_R: if (nib == 4'd0 && !ay.zero) pc <= pc4;
                c8ie_pkg::OPC_LD_I, c8ie_pkg::OPC_ADD_I, c8ie_pkg::OPC_RND: wx <= 1'b1;
                c8ie_pkg::OPC_ALU: begin
                  case (nib) inside
                    c8ie_pkg::AS_MOV, c8ie_pkg::AS_OR, c8ie_pkg::AS_AND,
                    c8ie_pkg::AS_XOR: wx <= 1'b1;
                    c8ie_pkg::AS_ADD, c8ie_pkg::AS_SUB, c8ie_pkg::AS_SUBN: begin
                      wx <= 1'b1;
                      wf <= 1'b1;
                    end
                    c8ie_pkg::AS_SHR, c8ie_pkg::AS_SHL: begin
                      wx <= 1'b1;
                      wy <= 1'b1;
                      wf <= 1'b1;
                    end
                    default: wx <= 1'b0;
                  endcase
                end
                c8ie_pkg::OPC_LDI: idx <= nnn;
                c8ie_pkg::OPC_JPV: pc <= ay.res;
                c8ie_pkg::OPC_DRW: begin
                  if (nib == 4'd0) begin
                    flg   <= 1'b0;
                    wf    <= 1'b1;
                    state <= S_WF;
                  end else begin
                    state <= S_DA;
                  end
                end
                c8ie_pkg::OPC_MISC: begin
                  unique case (nn)
                    c8ie_pkg::FS_ADDI:  idx <= ay.res;
                    c8ie_pkg::FS_BCD:   state <= S_B0;
                    c8ie_pkg::FS_STORE: state <= S_S5R;
                    c8ie_pkg::FS_LOAD:  state <= S_S6R;
                    default:            state <= S_WY;
                  endcase
                end
                default: state <= S_WY;
              endcase
            end
            default: state <= S_TX;
          endcase
        end
        S_MRD: begin
          rdat  <= m_q;
          state <= S_TX;
        end
        S_PRD: begin
          rdat  <= cur.address[11] ? 8'd0 : {7'd0, f_q[cur.address[5:0]]};
          state <= S_TX;
        end
        S_CLS: begin
          cnt <= cnt + 12'd1;
          if (cnt[4:0] == 5'(c8ie_pkg::SCR_H - 1)) begin
            state <= S_TX;
          end
        end
        S_WY: state <= S_WX;
        S_WX: state <= S_WF;
        S_WF: state <= S_TX;
        S_DA: state <= S_DD;
        S_DD: begin
          hit <= hit | (|(f_q & dmask));
          if (j == 4'(nib - 4'd1)) begin
            flg   <= hit | (|(f_q & dmask));
            wf    <= 1'b1;
            state <= S_WF;
          end else begin
            j     <= j + 4'd1;
            state <= S_DA;
          end
        end
        S_B0: state <= S_B1;
        S_B1: state <= S_B2;
        S_B2: state <= S_TX;
        S_S5R: state <= S_S5W;
        S_S6R: state <= S_S6W;
        S_S5W, S_S6W: begin
          idx <= idx + 12'd1;
          j   <= j + 4'd1;
          if (j == rx) begin
            state <= S_TX;
          end else begin
            state <= (state == S_S5W) ? S_S5R : S_S6R;
          end
        end
        S_TX: state <= S_TF;
        S_TF: begin
          tgt   <= v_q;
          state <= S_TD;
        end
        S_TD: begin
          if (!(rsp_valid && rsp_stall)) begin
            rsp.program_counter <= pc;
            rsp.index_value     <= idx;
            rsp.flag_value      <= v_q;
            rsp.target_value    <= tgt;
            rsp.read_data       <= rdat;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The memory clearing sweep never overlaps a pending response.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !rsp_valid)
    else $error("response pending during memory clear");

  // The sprite loop is only entered for a nonzero row count.
  a_draw_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DD) |-> (cur.instruction[3:0] != 4'd0))
    else $error("draw loop running with zero rows");

  // The index register holds while no item is in work.
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(idx))
    else $error("index register changed while idle");

endmodule

// ===== tb/sv/tb_chip8_instruction_executor_core.sv =====
// Self-checking testbench for the CHIP-8 execute unit: random and directed words,
// a behavioral machine model, and field-by-field comparison of every response.
// Depends on c8ie_pkg and chip8_instruction_executor_core.
`timescale 1ns / 1ps

module tb_chip8_instruction_executor_core;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  c8ie_pkg::in_t  req;
  logic rsp_valid;
  logic rsp_stall;
  c8ie_pkg::out_t rsp;

  chip8_instruction_executor_core i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Model of the machine state.
  logic [7:0]  mdl_v [16];
  logic [11:0] mdl_i;
  logic [11:0] mdl_pc;
  logic [7:0]  mdl_mem [c8ie_pkg::MEM_BYTES];
  logic        mdl_fb [c8ie_pkg::SCR_W*c8ie_pkg::SCR_H];

  c8ie_pkg::in_t  pending_words [$];
  c8ie_pkg::out_t expected_rsp [$];
  c8ie_pkg::in_t  drv_word;
  int   send_idle_pct;
  int   stall_pct;
  int   mismatches = 0;
  int   checked = 0;
  int   cycles = 0;
  bit   stim_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance PC by two with 12-bit wrap.
  function automatic logic [11:0] pc_plus2(input logic [11:0] p);
    return p + 12'd2;
  endfunction

  // Apply one word to the model and return the expected response.
  function automatic c8ie_pkg::out_t machine_step(input c8ie_pkg::in_t w);
    c8ie_pkg::out_t r;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy;
    logic [11:0] nnn;
    logic [8:0] sum;
    logic hit;
    logic [7:0] bits;
    int col0, row0, row, p;
    x = w.instruction[11:8];
    y = w.instruction[7:4];
    n = w.instruction[3:0];
    nn = w.instruction[7:0];
    nnn = w.instruction[11:0];
    r = '0;
    case (w.operation)
      c8ie_pkg::OP_EXEC: begin
        mdl_pc = pc_plus2(mdl_pc);
        vx = mdl_v[x];
        vy = mdl_v[y];
        case (w.instruction[15:12])
          c8ie_pkg::OPC_SYS: begin
            if (w.instruction == c8ie_pkg::INS_CLS)
              for (int k = 0; k < c8ie_pkg::SCR_W*c8ie_pkg::SCR_H; k++) mdl_fb[k] = 1'b0;
          end
          c8ie_pkg::OPC_JP: mdl_pc = nnn;
          c8ie_pkg::OPC_SE_I: if (vx == nn) mdl_pc = pc_plus2(mdl_pc);
          c8ie_pkg::OPC_SNE_I: if (vx != nn) mdl_pc = pc_plus2(mdl_pc);
          c8ie_pkg::OPC_SE_R: if (n == 4'h0 && vx == vy) mdl_pc = pc_plus2(mdl_pc);
          c8ie_pkg::OPC_SNE_R: if (n == 4'h0 && vx != vy) mdl_pc = pc_plus2(mdl_pc);
          c8ie_pkg::OPC_LD_I: mdl_v[x] = nn;
          c8ie_pkg::OPC_ADD_I: mdl_v[x] = vx + nn;
          c8ie_pkg::OPC_ALU: begin
            case (n)
              c8ie_pkg::AS_MOV: mdl_v[x] = vy;
              c8ie_pkg::AS_OR: mdl_v[x] = vx | vy;
              c8ie_pkg::AS_AND: mdl_v[x] = vx & vy;
              c8ie_pkg::AS_XOR: mdl_v[x] = vx ^ vy;
              c8ie_pkg::AS_ADD: begin
                sum = {1'b0, vx} + {1'b0, vy};
                mdl_v[x] = sum[7:0];
                mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, sum[8]};
              end
              c8ie_pkg::AS_SUB: begin
                mdl_v[x] = vx - vy;
                mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, vx >= vy};
              end
              c8ie_pkg::AS_SUBN: begin
                mdl_v[x] = vy - vx;
                mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, vy >= vx};
              end
              c8ie_pkg::AS_SHR: begin
                mdl_v[y] = vy >> 1;
                mdl_v[x] = vy >> 1;
                mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, vy[0]};
              end
              c8ie_pkg::AS_SHL: begin
                mdl_v[y] = vy << 1;
                mdl_v[x] = vy << 1;
                mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, vy[7]};
              end
              default: ;
            endcase
          end
          c8ie_pkg::OPC_LDI: mdl_i = nnn;
          c8ie_pkg::OPC_JPV: mdl_pc = 12'(mdl_v[0]) + nnn;
          c8ie_pkg::OPC_RND: mdl_v[x] = w.random_byte & nn;
          c8ie_pkg::OPC_DRW: begin
            hit = 1'b0;
            col0 = vx % c8ie_pkg::SCR_W;
            row0 = vy % c8ie_pkg::SCR_H;
            for (int j = 0; j < n; j++) begin
              bits = mdl_mem[12'(mdl_i + 12'(j))];
              row = (row0 + j) % c8ie_pkg::SCR_H;
              for (int k = 0; k < 8; k++) begin
                p = row * c8ie_pkg::SCR_W + (col0 + k) % c8ie_pkg::SCR_W;
                if (bits[7-k]) begin
                  if (mdl_fb[p]) hit = 1'b1;
                  mdl_fb[p] = ~mdl_fb[p];
                end
              end
            end
            mdl_v[c8ie_pkg::REG_FLAG] = {7'd0, hit};
          end
          c8ie_pkg::OPC_MISC: begin
            case (nn)
              c8ie_pkg::FS_ADDI: mdl_i = mdl_i + 12'(vx);
              c8ie_pkg::FS_BCD: begin
                mdl_mem[mdl_i] = vx / 100;
                mdl_mem[12'(mdl_i + 12'd1)] = (vx / 10) % 10;
                mdl_mem[12'(mdl_i + 12'd2)] = vx % 10;
              end
              c8ie_pkg::FS_STORE: begin
                for (int j = 0; j <= x; j++) begin
                  mdl_mem[mdl_i] = mdl_v[j];
                  mdl_i = mdl_i + 12'd1;
                end
              end
              c8ie_pkg::FS_LOAD: begin
                for (int j = 0; j <= x; j++) begin
                  mdl_v[j] = mdl_mem[mdl_i];
                  mdl_i = mdl_i + 12'd1;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8ie_pkg::OP_WRITE: mdl_mem[w.address] = w.write_data;
      c8ie_pkg::OP_READ: r.read_data = mdl_mem[w.address];
      default: begin
        if (w.address < c8ie_pkg::SCR_W*c8ie_pkg::SCR_H)
          r.read_data = {7'd0, mdl_fb[w.address]};
      end
    endcase
    r.program_counter = mdl_pc;
    r.index_value = mdl_i;
    r.flag_value = mdl_v[c8ie_pkg::REG_FLAG];
    r.target_value = mdl_v[x];
    return r;
  endfunction

  function automatic c8ie_pkg::in_t make_word(input logic [1:0] op, input logic [15:0] ins,
                                              input logic [11:0] a, input logic [7:0] d);
    c8ie_pkg::in_t w;
    w.operation = op;
    w.instruction = ins;
    w.address = a;
    w.write_data = d;
    w.random_byte = 8'($urandom);
    return w;
  endfunction

  // Random instruction biased toward useful opcodes and small draws.
  function automatic logic [15:0] rand_instruction();
    logic [15:0] ins;
    ins = 16'($urandom);
    case ($urandom_range(0, 19))
      0: ins = c8ie_pkg::INS_CLS;
      1, 2: ins[15:12] = c8ie_pkg::OPC_LD_I;
      3: ins[15:12] = c8ie_pkg::OPC_ADD_I;
      4, 5, 6: begin
        ins[15:12] = c8ie_pkg::OPC_ALU;
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 8))
            0: ins[3:0] = c8ie_pkg::AS_MOV;
            1: ins[3:0] = c8ie_pkg::AS_OR;
            2: ins[3:0] = c8ie_pkg::AS_AND;
            3: ins[3:0] = c8ie_pkg::AS_XOR;
            4: ins[3:0] = c8ie_pkg::AS_ADD;
            5: ins[3:0] = c8ie_pkg::AS_SUB;
            6: ins[3:0] = c8ie_pkg::AS_SHR;
            7: ins[3:0] = c8ie_pkg::AS_SUBN;
            default: ins[3:0] = c8ie_pkg::AS_SHL;
          endcase
        end
      end
      7: ins[15:12] = c8ie_pkg::OPC_SE_I;
      8: ins[15:12] = c8ie_pkg::OPC_SNE_I;
      9: begin
        ins[15:12] = $urandom_range(0, 1) ? c8ie_pkg::OPC_SE_R : c8ie_pkg::OPC_SNE_R;
        if ($urandom_range(0, 3) != 0) ins[3:0] = 4'h0;
      end
      10: ins[15:12] = c8ie_pkg::OPC_LDI;
      11: ins[15:12] = c8ie_pkg::OPC_RND;
      12, 13: begin
        ins[15:12] = c8ie_pkg::OPC_DRW;
        ins[3:0] = ($urandom_range(0, 9) == 0) ? 4'hF : 4'($urandom_range(0, 5));
      end
      14, 15: begin
        ins[15:12] = c8ie_pkg::OPC_MISC;
        case ($urandom_range(0, 4))
          0: ins[7:0] = c8ie_pkg::FS_ADDI;
          1: ins[7:0] = c8ie_pkg::FS_BCD;
          2: ins[7:0] = c8ie_pkg::FS_STORE;
          3: ins[7:0] = c8ie_pkg::FS_LOAD;
          default: ;
        endcase
        if (ins[7:0] inside {c8ie_pkg::FS_STORE, c8ie_pkg::FS_LOAD} &&
            $urandom_range(0, 3) != 0)
          ins[11:8] = 4'($urandom_range(0, 3));
      end
      16: ins[15:12] = c8ie_pkg::OPC_JP;
      17: ins[15:12] = c8ie_pkg::OPC_JPV;
      default: ;
    endcase
    return ins;
  endfunction

  // Driver: present queued words, hold a word while it is stalled.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else if (!req_valid || !req_stall) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_word = pending_words.pop_front();
        req <= drv_word;
        req_valid <= 1'b1;
        expected_rsp.push_back(machine_step(drv_word));
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall and response monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected response %h", rsp);
        end else begin
          if (rsp !== expected_rsp[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: pc %h/%h i %h/%h vf %h/%h vx %h/%h rd %h/%h (exp/act)",
                expected_rsp[0].program_counter, rsp.program_counter,
                expected_rsp[0].index_value, rsp.index_value,
                expected_rsp[0].flag_value, rsp.flag_value,
                expected_rsp[0].target_value, rsp.target_value,
                expected_rsp[0].read_data, rsp.read_data);
          end
          void'(expected_rsp.pop_front());
          checked <= checked + 1;
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > 900000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Wait until the queue of pending words has drained.
  task automatic drain_words();
    while (pending_words.size() > 0) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    c8ie_pkg::in_t w;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1: w = make_word(c8ie_pkg::OP_WRITE, 16'($urandom), 12'($urandom), 8'($urandom));
        2: w = make_word(c8ie_pkg::OP_READ, 16'($urandom), 12'($urandom), 8'($urandom));
        3: w = make_word(c8ie_pkg::OP_PIXEL, 16'($urandom), 12'($urandom), 8'($urandom));
        default: w = make_word(c8ie_pkg::OP_EXEC, rand_instruction(), 12'($urandom),
                               8'($urandom));
      endcase
      pending_words.push_back(w);
    end
    drain_words();
  endtask

  initial begin
    mdl_i = '0;
    mdl_pc = c8ie_pkg::PC_RESET;
    for (int k = 0; k < 16; k++) mdl_v[k] = '0;
    for (int k = 0; k < c8ie_pkg::MEM_BYTES; k++) mdl_mem[k] = '0;
    for (int k = 0; k < c8ie_pkg::SCR_W*c8ie_pkg::SCR_H; k++) mdl_fb[k] = 1'b0;
    stim_done = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words: extremes, flags, skips, draw wrap and collision, block moves.
    pending_words.push_back(make_word(c8ie_pkg::OP_WRITE, 16'hFFFF, 12'hFFF, 8'hFF));
    pending_words.push_back(make_word(c8ie_pkg::OP_READ, 16'h0000, 12'hFFF, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_PIXEL, 16'hFFFF, 12'hFFF, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h60FF, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h6101, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h8F14, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h8015, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h8017, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h801E, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h8016, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h30FF, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h9010, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hAFFF, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h6A3F, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h6B1F, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hDAB3, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hDAB3, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hDAB0, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hF033, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hFF55, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hFF65, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h00E0, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hC0F0, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'hBFFF, 12'h000, 8'h00));
    pending_words.push_back(make_word(c8ie_pkg::OP_EXEC, 16'h00EE, 12'h000, 8'h00));
    drain_words();

    // Hold off until every expected response has arrived.
    while (expected_rsp.size() > 0) @(posedge clk);

    random_phase(400);
    send_idle_pct = 50;
    random_phase(400);
    send_idle_pct = 0;
    stall_pct = 50;
    random_phase(400);
    send_idle_pct = 30;
    stall_pct = 30;
    random_phase(450);
    stall_pct = 0;
    send_idle_pct = 0;
    stim_done = 1'b1;
  end

  // Final check once stimulus has drained.
  initial begin
    wait (stim_done);
    while (expected_rsp.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d responses over execute, memory and pixel words", checked);
    $display("with sender gaps and receiver stalls in several mixes.");
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
